// ----- sv/wps_pkg.sv -----
`default_nettype none

package wps_pkg;

    localparam int MAX_WAYPOINTS_DEF = 256;
    localparam int FRAC_BITS         = 16;
    localparam int COORD_W           = 32;
    localparam int THR_W             = 31;
    localparam int INDEX_W           = 8;
    localparam int SQ_W              = 2 * COORD_W;
    localparam int DIST_W            = SQ_W + 2;

    localparam logic [THR_W-1:0] THR_RESET =
        THR_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    localparam logic [1:0] CMD_WAYPOINT = 2'd0;
    localparam logic [1:0] CMD_POSITION = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_MUL,
        S_CMP,
        S_EREAD,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ----- sv/waypoint_sequencer_top.sv -----
`default_nettype none

// Waypoint sequencer. Waypoint transfers load a path into on-chip stores (y negated,
// saturating); the last one starts a nearest-waypoint search that runs the read,
// difference, multiply and compare states for each stored waypoint, one shared
// 32x32 multiplier squaring the three coordinate differences in turn, then reads
// and presents the result. A position update with publishing active runs the same
// states for the closeness check (same multiplier, also squaring the threshold)
// and the read and emit states when it advances to a new target. Input ready is
// low while an item is worked on; one result register lets a new input be taken
// while the last result still waits.
module waypoint_sequencer_top
    import wps_pkg::*;
#(
    parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire  [THR_W-1:0]        i_cfg_close_threshold,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire  [1:0]              i_command,
    input  wire  [COORD_W-1:0]      i_coord_x,
    input  wire  [COORD_W-1:0]      i_coord_y,
    input  wire  [COORD_W-1:0]      i_coord_z,
    input  wire                     i_last_of_path,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output logic [COORD_W-1:0]      o_target_x,
    output logic [COORD_W-1:0]      o_target_y,
    output logic [COORD_W-1:0]      o_target_z,
    output logic [INDEX_W-1:0]      o_target_index
);

    localparam int IW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);
    localparam logic [CW-1:0] LEN_MAX = CW'(MAX_WAYPOINTS);

    logic [COORD_W-1:0] mem_x [MAX_WAYPOINTS];
    logic [COORD_W-1:0] mem_y [MAX_WAYPOINTS];
    logic [COORD_W-1:0] mem_z [MAX_WAYPOINTS];

    t_state             r_state, n_state;
    logic [CW-1:0]      r_len;
    logic [CW-1:0]      r_ptr;
    logic               r_pub;
    logic               r_loading;
    logic               r_search;
    logic [COORD_W-1:0] r_here_x, r_here_y, r_here_z;
    logic [THR_W-1:0]   r_thr;
    logic [IW-1:0]      r_idx;
    logic [1:0]         r_k;
    logic [COORD_W-1:0] r_rd_x, r_rd_y, r_rd_z;
    logic [COORD_W-1:0] r_mag0, r_mag1, r_mag2;
    logic [SQ_W-1:0]    r_prod;
    logic [DIST_W-1:0]  r_acc;
    logic [DIST_W-1:0]  r_best;
    logic [IW-1:0]      r_best_idx;

    logic               w_accept;
    logic               w_emit_load;
    logic [CW-1:0]      w_len_eff;
    logic               w_room;
    logic [COORD_W-1:0] w_neg_y;
    logic [COORD_W-1:0] w_op;
    logic               w_better;
    logic [IW-1:0]      w_sel_idx;
    logic               w_more;
    logic               w_close;
    logic [CW-1:0]      w_ptr_next;
    logic [COORD_W:0]   w_dx, w_dy, w_dz;

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W:0] d);
        logic [COORD_W:0] m;
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[COORD_W-1:0];
    endfunction

    assign w_len_eff  = r_loading ? r_len : '0;
    assign w_room     = (w_len_eff < LEN_MAX);
    assign w_neg_y    = (i_coord_y == {1'b1, {(COORD_W-1){1'b0}}}) ?
                        {1'b0, {(COORD_W-1){1'b1}}} : (~i_coord_y + 1'b1);
    assign w_dx       = {r_here_x[COORD_W-1], r_here_x} - {r_rd_x[COORD_W-1], r_rd_x};
    assign w_dy       = {r_here_y[COORD_W-1], r_here_y} - {r_rd_y[COORD_W-1], r_rd_y};
    assign w_dz       = {r_here_z[COORD_W-1], r_here_z} - {r_rd_z[COORD_W-1], r_rd_z};
    assign w_better   = (r_idx == '0) || (r_acc < r_best);
    assign w_sel_idx  = w_better ? r_idx : r_best_idx;
    assign w_more     = ((CW'(r_idx) + 1'b1) < r_len);
    assign w_close    = (r_acc < {2'b00, r_prod});
    assign w_ptr_next = r_ptr + 1'b1;

    always_comb begin
        case (r_k)
            2'd0:    w_op = r_mag0;
            2'd1:    w_op = r_mag1;
            2'd2:    w_op = r_mag2;
            default: w_op = {1'b0, r_thr};
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == CMD_WAYPOINT && i_last_of_path) begin
                        n_state = S_READ;
                    end else if (i_command == CMD_POSITION && r_len != '0 && r_pub
                                 && r_ptr < r_len) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ:  n_state = S_DIFF;
            S_DIFF:  n_state = S_MUL;
            S_MUL: begin
                if (r_k == 2'd3) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_search) begin
                    n_state = w_more ? S_READ : S_EREAD;
                end else if (w_close && w_ptr_next < r_len) begin
                    n_state = S_EREAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EREAD: n_state = S_EMIT;
            S_EMIT: begin
                if (!o_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        w_accept    = o_in_ready && i_in_valid;
        w_emit_load = (r_state == S_EMIT) && (!o_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_command == CMD_WAYPOINT && w_room) begin
            mem_x[w_len_eff[IW-1:0]] <= i_coord_x;
            mem_y[w_len_eff[IW-1:0]] <= w_neg_y;
            mem_z[w_len_eff[IW-1:0]] <= i_coord_z;
        end
        r_rd_x <= mem_x[r_idx];
        r_rd_y <= mem_y[r_idx];
        r_rd_z <= mem_z[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_ptr       <= '0;
            r_pub       <= 1'b0;
            r_loading   <= 1'b0;
            r_search    <= 1'b0;
            r_here_x    <= '0;
            r_here_y    <= '0;
            r_here_z    <= '0;
            r_thr       <= THR_RESET;
            r_idx       <= '0;
            r_k         <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_thr <= i_cfg_close_threshold;
            end
            o_out_valid <= w_emit_load || (o_out_valid && !i_out_ready);

            if (w_accept) begin
                unique case (i_command)
                    CMD_WAYPOINT: begin
                        r_len <= w_room ? (w_len_eff + 1'b1) : w_len_eff;
                        r_loading <= !i_last_of_path;
                        if (i_last_of_path) begin
                            r_pub    <= 1'b1;
                            r_search <= 1'b1;
                            r_idx    <= '0;
                        end else if (!r_loading) begin
                            r_pub <= 1'b0;
                        end
                    end
                    CMD_POSITION: begin
                        r_here_x <= i_coord_x;
                        r_here_y <= i_coord_y;
                        r_here_z <= i_coord_z;
                        r_search <= 1'b0;
                        r_idx    <= r_ptr[IW-1:0];
                    end
                    CMD_CLEAR: begin
                        r_len     <= '0;
                        r_loading <= 1'b0;
                        r_pub     <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end

            if (r_state == S_DIFF) begin
                r_k <= '0;
            end
            if (r_state == S_MUL) begin
                r_k <= r_k + 1'b1;
            end

            if (r_state == S_CMP) begin
                if (r_search) begin
                    if (w_more) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_idx <= w_sel_idx;
                        r_ptr <= CW'(w_sel_idx);
                    end
                end else if (w_close) begin
                    r_ptr <= w_ptr_next;
                    if (w_ptr_next < r_len) begin
                        r_idx <= w_ptr_next[IW-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIFF) begin
            r_mag0 <= abs_diff(w_dx);
            r_mag1 <= abs_diff(w_dy);
            r_mag2 <= abs_diff(w_dz);
        end
        if (r_state == S_MUL) begin
            r_prod <= SQ_W'(w_op) * SQ_W'(w_op);
            if (r_k == 2'd0) begin
                r_acc <= '0;
            end else begin
                r_acc <= r_acc + {2'b00, r_prod};
            end
        end
        if (r_state == S_CMP && r_search && w_better) begin
            r_best     <= r_acc;
            r_best_idx <= r_idx;
        end
        if (w_emit_load) begin
            o_target_x     <= r_rd_x;
            o_target_y     <= r_rd_y;
            o_target_z     <= r_rd_z;
            o_target_index <= INDEX_W'(r_ptr);
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_MAX)
        else $error("path length beyond store capacity");

    a_emit_in_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_ptr < r_len))
        else $error("emitting a target outside the path");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside the emit step");

    a_mul_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_k == 2'd3) |=> (r_state == S_CMP))
        else $error("multiply sequence overran");

endmodule

`default_nettype wire

// ----- verif/tb_waypoint_sequencer_top.sv -----
module tb_waypoint_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wps_pkg::*;

    localparam int          WP_CAP     = MAX_WAYPOINTS_DEF;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int          SETTLE     = 16;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [7:0]  idx;
    } t_target;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } t_stim_row;

    typedef struct packed {
        t_stim_row item;
        logic      typed;
        logic      want;
        t_target   tgt;
    } t_plan_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [THR_W-1:0]   i_cfg_close_threshold;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_command;
    logic [COORD_W-1:0] i_coord_x;
    logic [COORD_W-1:0] i_coord_y;
    logic [COORD_W-1:0] i_coord_z;
    logic               i_last_of_path;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [COORD_W-1:0] o_target_x;
    logic [COORD_W-1:0] o_target_y;
    logic [COORD_W-1:0] o_target_z;
    logic [INDEX_W-1:0] o_target_index;

    waypoint_sequencer_top dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_close_threshold (i_cfg_close_threshold),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_command             (i_command),
        .i_coord_x             (i_coord_x),
        .i_coord_y             (i_coord_y),
        .i_coord_z             (i_coord_z),
        .i_last_of_path        (i_last_of_path),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_target_x            (o_target_x),
        .o_target_y            (o_target_y),
        .o_target_z            (o_target_z),
        .o_target_index        (o_target_index)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // follower state
    logic [31:0] wp_x [WP_CAP];
    logic [31:0] wp_y [WP_CAP];
    logic [31:0] wp_z [WP_CAP];
    int unsigned n_stored;
    int unsigned aim_idx;
    bit          guiding;
    bit          filling;
    logic [31:0] pos_x, pos_y, pos_z;
    logic [30:0] near_limit;

    t_target     target_q [$];
    t_target     got_want;
    bit          steady;
    int          fail_count;
    int          item_count;
    int          target_count;
    int          thr_writes;

    function automatic logic [65:0] sq_gap(logic [31:0] p, logic [31:0] q);
        longint      d;
        logic [65:0] m;
        d = longint'($signed(p)) - longint'($signed(q));
        m = (d < 0) ? 66'(-d) : 66'(d);
        return m * m;
    endfunction

    function automatic logic [65:0] dist_to(int unsigned i);
        return sq_gap(pos_x, wp_x[i]) + sq_gap(pos_y, wp_y[i]) + sq_gap(pos_z, wp_z[i]);
    endfunction

    function automatic t_target target_at(int unsigned i);
        return '{wp_x[i], wp_y[i], wp_z[i], i[7:0]};
    endfunction

    function automatic t_stim_row row(logic [1:0] cmd, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z, logic last);
        return '{cmd, x, y, z, last};
    endfunction

    function automatic logic [31:0] jitter(logic [31:0] c, longint span);
        longint r;
        r = longint'({$urandom, $urandom} >> 1) % (2 * span + 1);
        return 32'(longint'($signed(c)) + r - span);
    endfunction

    // advance the follower by one transfer and work out the target it commands
    task automatic follow(input t_stim_row r, output bit hit, output t_target t);
        logic [65:0] best;
        logic [65:0] d;
        int unsigned best_i;
        int unsigned i;
        hit = 1'b0;
        t = '0;
        case (r.cmd)
            CMD_WAYPOINT: begin
                if (!filling) begin
                    n_stored = 0;
                    guiding = 1'b0;
                    filling = 1'b1;
                end
                if (n_stored < WP_CAP) begin
                    wp_x[n_stored] = r.x;
                    wp_y[n_stored] = (r.y == 32'h8000_0000) ? 32'h7FFF_FFFF : ~r.y + 32'd1;
                    wp_z[n_stored] = r.z;
                    n_stored++;
                end
                if (r.last) begin
                    filling = 1'b0;
                    best = '0;
                    best_i = 0;
                    for (i = 0; i < n_stored; i++) begin
                        d = dist_to(i);
                        if (i == 0 || d < best) begin
                            best = d;
                            best_i = i;
                        end
                    end
                    aim_idx = best_i;
                    guiding = 1'b1;
                    if (aim_idx < n_stored) begin
                        hit = 1'b1;
                        t = target_at(aim_idx);
                    end
                end
            end
            CMD_POSITION: begin
                pos_x = r.x;
                pos_y = r.y;
                pos_z = r.z;
                if (n_stored != 0 && guiding && aim_idx < n_stored) begin
                    if (dist_to(aim_idx) < 66'(near_limit) * 66'(near_limit)) begin
                        aim_idx++;
                        if (aim_idx < n_stored) begin
                            hit = 1'b1;
                            t = target_at(aim_idx);
                        end
                    end
                end
            end
            CMD_CLEAR: begin
                n_stored = 0;
                filling = 1'b0;
                guiding = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic put_item(input t_stim_row r, input bit typed = 1'b0,
                            input bit want = 1'b0, input t_target tgt = '0);
        bit      hit;
        t_target t;
        while (!steady && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= r.cmd;
        i_coord_x      <= r.x;
        i_coord_y      <= r.y;
        i_coord_z      <= r.z;
        i_last_of_path <= r.last;
        do @(posedge i_clk); while (!o_in_ready);
        follow(r, hit, t);
        if (typed) begin
            hit = want;
            t = tgt;
        end
        if (hit) target_q.push_back(t);
        if (r.cmd != CMD_UNUSED) item_count++;
    endtask

    // hold the input side until every target is out and the block has gone quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (target_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_threshold(input logic [30:0] v);
        settle();
        i_cfg_we              <= 1'b1;
        i_cfg_close_threshold <= v;
        @(posedge i_clk);
        near_limit = v;
        thr_writes++;
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_path(input int unsigned n, input bit clean);
        logic [31:0] bx, by, bz, px, py, pz;
        longint      span, reach;
        int unsigned steps;
        int unsigned k;
        span = $urandom_range(1) ? longint'(near_limit) * 4 + 4
                                 : longint'($urandom_range(32'h10_0000));
        bx = $urandom;
        by = $urandom;
        bz = $urandom;
        for (k = 0; k < n; k++) begin
            if (!clean && $urandom_range(99) < 8)
                put_item(row($urandom_range(1) ? CMD_POSITION : CMD_UNUSED, jitter(bx, span),
                             jitter(by, span), jitter(bz, span), 1'($urandom_range(1))));
            else if (!clean && $urandom_range(99) < 3)
                put_item(row(CMD_CLEAR, $urandom, $urandom, $urandom, 1'($urandom_range(1))));
            py = jitter(by, span);
            put_item(row(CMD_WAYPOINT, jitter(bx, span), ~py + 32'd1, jitter(bz, span),
                         k == n - 1));
        end
        steps = (n > 9) ? 30 : 3 * n + 2;
        repeat (steps) begin
            reach = $urandom_range(1) ? longint'(near_limit) / 2
                                      : longint'(near_limit) * 3 + 2;
            if (guiding && aim_idx < n_stored) begin
                px = jitter(wp_x[aim_idx], reach);
                py = jitter(wp_y[aim_idx], reach);
                pz = jitter(wp_z[aim_idx], reach);
            end else begin
                px = jitter(bx, span);
                py = jitter(by, span);
                pz = jitter(bz, span);
            end
            put_item(row(CMD_POSITION, px, py, pz, 1'($urandom_range(1))));
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (target_q.size() == 0) begin
                $error("target transfer with none pending: index %0d", o_target_index);
                fail_count++;
            end else begin
                got_want = target_q.pop_front();
                check_field("target_x", got_want.x, o_target_x);
                check_field("target_y", got_want.y, o_target_y);
                check_field("target_z", got_want.z, o_target_z);
                check_field("target_index", 32'(got_want.idx), 32'(o_target_index));
                target_count++;
            end
        end
        i_out_ready <= steady || ($urandom_range(99) >= 38);
    end

    initial begin
        #(10_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_plan_row   plan [$];
        logic [30:0] thr_plan [6];
        int unsigned stop_at;
        int unsigned pick;
        int          ph;

        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_close_threshold = '0;
        i_in_valid            = 1'b0;
        i_command             = CMD_WAYPOINT;
        i_coord_x             = '0;
        i_coord_y             = '0;
        i_coord_z             = '0;
        i_last_of_path        = 1'b0;
        i_out_ready           = 1'b0;
        n_stored   = 0;
        aim_idx    = 0;
        guiding    = 1'b0;
        filling    = 1'b0;
        pos_x      = '0;
        pos_y      = '0;
        pos_z      = '0;
        near_limit = THR_RESET;
        steady     = 1'b0;

        // empty path, unused command, clear, extremes, saturation, ties, threshold edge
        plan.push_back('{row(CMD_POSITION, 32'h0, 32'h0, 32'h0, 1'b1), 1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1),
                         1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 1'b1), 1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_POSITION, 32'h0, 32'h0, 32'h0, 1'b0), 1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_WAYPOINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0),
                         1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_WAYPOINT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0),
                         1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_WAYPOINT, 32'h0, 32'h0, 32'h0, 1'b1),
                         1'b1, 1'b1, '{32'h0, 32'h0, 32'h0, 8'd2}});
        plan.push_back('{row(CMD_POSITION, 32'h0, 32'h0, 32'h0, 1'b0), 1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_POSITION, 32'h0, 32'h0, 32'h0, 1'b0), 1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_WAYPOINT, 32'h3_0000, 32'h0, 32'h0, 1'b0), 1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_WAYPOINT, 32'h1_0000, 32'h0, 32'h0, 1'b0), 1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_WAYPOINT, 32'h0, 32'h0, 32'h1_0000, 1'b1),
                         1'b1, 1'b1, '{32'h1_0000, 32'h0, 32'h0, 8'd1}});
        plan.push_back('{row(CMD_POSITION, 32'h1_0000, 32'h0, 32'h0, 1'b1),
                         1'b1, 1'b1, '{32'h0, 32'h0, 32'h1_0000, 8'd2}});
        plan.push_back('{row(CMD_POSITION, 32'd6554, 32'h0, 32'h1_0000, 1'b0), 1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_POSITION, 32'd6553, 32'h0, 32'h1_0000, 1'b0), 1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_POSITION, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0),
                         1'b0, 1'b0, '0});
        plan.push_back('{row(CMD_WAYPOINT, 32'h7FFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF, 1'b0),
                         1'b0, 1'b0, '0});
        plan.push_back('{row(CMD_WAYPOINT, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 1'b1),
                         1'b0, 1'b0, '0});
        plan.push_back('{row(CMD_WAYPOINT, 32'h1234_5678, 32'h0, 32'h0, 1'b0), 1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_POSITION, 32'h1234_5678, 32'h0, 32'h0, 1'b0), 1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 1'b0), 1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_POSITION, 32'h0, 32'h0, 32'h0, 1'b0), 1'b1, 1'b0, '0});
        plan.push_back('{row(CMD_WAYPOINT, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_8000, 1'b1),
                         1'b0, 1'b0, '0});
        plan.push_back('{row(CMD_POSITION, 32'hFFFF_0100, 32'hFFFF_0000, 32'hFFFF_8000, 1'b0),
                         1'b0, 1'b0, '0});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) put_item(plan[k].item, plan[k].typed, plan[k].want, plan[k].tgt);

        thr_plan = '{31'd0, 31'h7FFF_FFFF, THR_RESET, 31'($urandom_range(32'h4_0000)),
                     31'($urandom), 31'($urandom_range(32'h2000))};
        for (ph = 0; ph < 6; ph++) begin
            load_threshold(thr_plan[ph]);
            steady = (ph == 3);
            // overfill the store once so the tail of the path is dropped
            if (ph == 2) run_path(WP_CAP + 20, 1'b1);
            stop_at = item_count + 240;
            while (item_count < stop_at) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    run_path(($urandom_range(39) == 0) ? $urandom_range(200, 300)
                                                       : $urandom_range(1, 8), 1'b0);
                end else if (pick < 85) begin
                    repeat ($urandom_range(1, 4))
                        put_item(row(2'($urandom_range(3)), $urandom, $urandom, $urandom,
                                     1'($urandom_range(1))));
                end else begin
                    put_item(row(CMD_CLEAR, $urandom, $urandom, $urandom,
                                 1'($urandom_range(1))));
                    repeat ($urandom_range(1, 3))
                        put_item(row(CMD_POSITION, $urandom, $urandom, $urandom,
                                     1'($urandom_range(1))));
                end
            end
        end
        steady = 1'b0;

        settle();
        repeat (20) @(posedge i_clk);

        $display("%0d transfers in, %0d targets checked, %0d threshold settings",
                 item_count, target_count, thr_writes);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/wps_pkg.sv
sv/waypoint_sequencer_top.sv
verif/tb_waypoint_sequencer_top.sv
